// ----- design/bsa_pkg.sv -----
package bsa_pkg;

  // default parameter values
  localparam int DEF_ZONES      = 8;
  localparam int DEF_MAX_SLOTS  = 1024;
  localparam int DEF_SLOT_BYTES = 16;
  localparam int DEF_PAGE_MULT  = 4;

  // zones beyond the mask width are never examined
  localparam int MASK_ZONES = 8;

  // config register indexes
  localparam logic [1:0] REG_PAGE_LEN   = 2'd0;
  localparam logic [1:0] REG_ZONE_COUNT = 2'd1;
  localparam logic [1:0] REG_TINY_MASK  = 2'd2;

  localparam int CFG_IDX_W   = 2;
  localparam int PAGE_LEN_W  = 17;
  localparam int ZONE_CNT_W  = 4;
  localparam int TINY_MASK_W = 8;
  localparam int CFG_DATA_W  = 17;

  localparam logic [PAGE_LEN_W-1:0] PAGE_LEN_RST = 17'd4096;

  // result field widths
  localparam int ZONE_IDX_W = 3;
  localparam int SLOT_IDX_W = 10;
  localparam int OFFSET_W   = 16;

  // zone header bytes ahead of the bitmap
  localparam int HDR_BYTES = 3;

  // page bytes (PAGE_MULT * page_len) and the dividend (bytes - 3) * 8
  localparam int BYTES_W = 21;
  localparam int NUM_W   = 24;

  // bitmap word geometry
  localparam int WORD_W     = 64;
  localparam int WORD_IDX_W = 6;
  localparam int GROUPS     = 8;
  localparam int GROUP_W    = 8;
  localparam int GROUP_IDX_W = 3;

  // lowest-clear-bit search result
  typedef struct packed {
    logic                  hit;
    logic [WORD_IDX_W-1:0] pos;
  } zf_t;

endpackage

// ----- design/bsa_bitmap_ram.sv -----
module bsa_bitmap_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bsa_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [bsa_pkg::WORD_W-1:0] rd_data
);

  logic [bsa_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bsa_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/bsa_slot_calc.sv -----
module bsa_slot_calc #(
  parameter int PAGE_MULT  = bsa_pkg::DEF_PAGE_MULT,
  parameter int SLOT_BYTES = bsa_pkg::DEF_SLOT_BYTES,
  parameter int MAX_SLOTS  = bsa_pkg::DEF_MAX_SLOTS,
  parameter int SLOT_W     = 11
) (
  input  logic                             clk,
  input  logic [bsa_pkg::PAGE_LEN_W-1:0]   page_len,
  output logic [SLOT_W-1:0]                slots
);

  // slots = (bytes - 3) * 8 / DIVISOR via reciprocal multiply, exact for NUM_W-bit dividends
  localparam int DIVISOR = SLOT_BYTES * 8 + 1;
  localparam int SHIFT   = bsa_pkg::NUM_W + $clog2(DIVISOR);
  localparam int RECIP_W = bsa_pkg::NUM_W + 2;
  localparam int PROD_W  = bsa_pkg::NUM_W + RECIP_W;
  localparam int QUO_W   = PROD_W - SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [bsa_pkg::BYTES_W-1:0] bytes;
  logic [bsa_pkg::NUM_W-1:0]   num_nxt;
  logic [bsa_pkg::NUM_W-1:0]   num_r;
  logic [PROD_W-1:0]           prod_r;
  logic [QUO_W-1:0]            quo;

  assign bytes = bsa_pkg::BYTES_W'(PAGE_MULT) * bsa_pkg::BYTES_W'(page_len);

  always_comb begin
    if (bytes < bsa_pkg::BYTES_W'(bsa_pkg::HDR_BYTES)) begin
      num_nxt = '0;
    end else begin
      num_nxt = bsa_pkg::NUM_W'(bytes - bsa_pkg::BYTES_W'(bsa_pkg::HDR_BYTES)) << 3;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    prod_r <= PROD_W'(num_r) * PROD_W'(RECIP);
  end

  assign quo = prod_r[PROD_W-1:SHIFT];

  always_comb begin
    if (quo > QUO_W'(MAX_SLOTS)) begin
      slots = SLOT_W'(MAX_SLOTS);
    end else begin
      slots = SLOT_W'(quo);
    end
  end

endmodule

// ----- design/bsa_zero_find.sv -----
module bsa_zero_find (
  input  logic                       clk,
  input  logic                       load,
  input  logic [bsa_pkg::WORD_W-1:0] word,
  output bsa_pkg::zf_t               result
);

  // stage 1: per byte, any clear bit and its lowest position
  logic [bsa_pkg::GROUPS-1:0]      grp_hit_nxt;
  logic [bsa_pkg::GROUP_IDX_W-1:0] grp_pos_nxt [bsa_pkg::GROUPS];
  logic [bsa_pkg::GROUPS-1:0]      grp_hit_r;
  logic [bsa_pkg::GROUP_IDX_W-1:0] grp_pos_r [bsa_pkg::GROUPS];

  always_comb begin
    for (int g = 0; g < bsa_pkg::GROUPS; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_pos_nxt[g] = '0;
      for (int b = bsa_pkg::GROUP_W - 1; b >= 0; b--) begin
        if (!word[g * bsa_pkg::GROUP_W + b]) begin
          grp_hit_nxt[g] = 1'b1;
          grp_pos_nxt[g] = bsa_pkg::GROUP_IDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_hit_r <= grp_hit_nxt;
      grp_pos_r <= grp_pos_nxt;
    end
  end

  // stage 2: lowest byte with a clear bit
  always_comb begin
    result = '0;
    for (int g = bsa_pkg::GROUPS - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        result.hit = 1'b1;
        result.pos = {bsa_pkg::GROUP_IDX_W'(g), grp_pos_r[g]};
      end
    end
  end

endmodule

// ----- design/bitmap_slot_allocator.sv -----
// Slot allocator, first fit over zone bitmaps held in one 64-bit-wide RAM.
// Sequence: an accepted request passes ST_CALC, then ST_ZONE per zone tried, and ST_READ,
//   ST_FIND1, ST_FIND2 per bitmap word read in each zone scanned, then ST_OFFS on a find.
// Throughput: one request at a time, busy drops in the strobe cycle; results cannot stall.
// Reset: rst_n (sync) restores config defaults, clears counts and control, then a RAM
//   clearing pass over all min(ZONES,8)*ceil(MAX_SLOTS/64) words (128 by default), busy high.
module bitmap_slot_allocator #(
  parameter int ZONES      = bsa_pkg::DEF_ZONES,
  parameter int MAX_SLOTS  = bsa_pkg::DEF_MAX_SLOTS,
  parameter int SLOT_BYTES = bsa_pkg::DEF_SLOT_BYTES,
  parameter int PAGE_MULT  = bsa_pkg::DEF_PAGE_MULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_request,
  // result channel
  output logic                              out_valid,
  output logic                              out_found,
  output logic [bsa_pkg::ZONE_IDX_W-1:0]    out_zone_index,
  output logic [bsa_pkg::SLOT_IDX_W-1:0]    out_slot_index,
  output logic [bsa_pkg::OFFSET_W-1:0]      out_byte_offset,
  // config port
  input  logic                              cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // geometry
  localparam int WPZ    = (MAX_SLOTS + 63) / 64;              // words per zone
  localparam int NZ     = (ZONES < bsa_pkg::MASK_ZONES) ? ZONES : bsa_pkg::MASK_ZONES;
  localparam int DEPTH  = NZ * WPZ;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW     = (WPZ > 1) ? $clog2(WPZ) : 1;
  localparam int ZI_W   = (NZ > 1) ? $clog2(NZ) : 1;
  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = SLOT_W + 1;
  localparam int JW     = WW + bsa_pkg::WORD_IDX_W;
  localparam int OFF_W  = JW + 10;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CALC  = 8'b0000_0100,
    ST_ZONE  = 8'b0000_1000,
    ST_READ  = 8'b0001_0000,
    ST_FIND1 = 8'b0010_0000,
    ST_FIND2 = 8'b0100_0000,
    ST_OFFS  = 8'b1000_0000
  } state_t;

  // config registers
  logic [bsa_pkg::PAGE_LEN_W-1:0]  page_len_r;
  logic [bsa_pkg::ZONE_CNT_W-1:0]  zone_count_r;
  logic [bsa_pkg::TINY_MASK_W-1:0] tiny_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_len_r   <= bsa_pkg::PAGE_LEN_RST;
      zone_count_r <= '0;
      tiny_mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsa_pkg::REG_PAGE_LEN:   page_len_r   <= cfg_wdata;
        bsa_pkg::REG_ZONE_COUNT: zone_count_r <= bsa_pkg::ZONE_CNT_W'(cfg_wdata);
        bsa_pkg::REG_TINY_MASK:  tiny_mask_r  <= bsa_pkg::TINY_MASK_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // control state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [1:0]        calc_cnt_r, calc_cnt_nxt;
  logic [SLOT_W-1:0] slots_r, slots_nxt;
  logic [3:0]        zone_r, zone_nxt;       // counts up to the mask width
  logic [AW-1:0]     base_r, base_nxt;       // first RAM word of zone_r
  logic [WW-1:0]     word_r, word_nxt;
  logic [JW-1:0]     slot_r, slot_nxt;
  logic [SLOT_W-1:0] used_cnt_r [NZ];
  logic              cnt_inc;

  // result registers
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [bsa_pkg::ZONE_IDX_W-1:0] out_zone_r, out_zone_nxt;
  logic [bsa_pkg::SLOT_IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [bsa_pkg::OFFSET_W-1:0]   out_offset_r, out_offset_nxt;

  // datapath
  logic [SLOT_W-1:0]          slots_calc;
  logic [AW-1:0]              rd_addr;
  logic [bsa_pkg::WORD_W-1:0] rd_data;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bsa_pkg::WORD_W-1:0] ram_wdata;
  logic [bsa_pkg::WORD_W-1:0] valid_mask;
  logic [bsa_pkg::WORD_W-1:0] scan_word;
  logic [CMP_W-1:0]           word_base;   // first slot of word_r
  logic [CMP_W-1:0]           next_base;   // first slot of word_r + 1
  logic [CMP_W-1:0]           remain;      // slots left from word_base
  logic [3:0]                 zone_limit;
  logic [ZI_W-1:0]            zi;
  logic [OFF_W-1:0]           offset_full;
  bsa_pkg::zf_t               zf;

  // slot count from page size, 2-stage reciprocal divide
  bsa_slot_calc #(
    .PAGE_MULT (PAGE_MULT),
    .SLOT_BYTES(SLOT_BYTES),
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_slot_calc (
    .clk     (clk),
    .page_len(page_len_r),
    .slots   (slots_calc)
  );

  // bitmap RAM; read and write of a word sit in different states, so no
  // forwarding is needed
  bsa_bitmap_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_bitmap_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // lowest clear bit, registered per byte then merged
  bsa_zero_find u_zero_find (
    .clk   (clk),
    .load  (state_r == ST_FIND1),
    .word  (scan_word),
    .result(zf)
  );

  assign rd_addr   = base_r + AW'(word_r);
  assign word_base = CMP_W'(word_r) << bsa_pkg::WORD_IDX_W;
  assign next_base = (CMP_W'(word_r) + CMP_W'(1)) << bsa_pkg::WORD_IDX_W;
  assign remain    = CMP_W'(slots_r) - word_base;
  assign zi        = zone_r[ZI_W-1:0];

  // bits at or above the slot count look used
  always_comb begin
    if (remain >= CMP_W'(bsa_pkg::WORD_W)) begin
      valid_mask = '1;
    end else begin
      valid_mask = (bsa_pkg::WORD_W'(1) << remain[bsa_pkg::WORD_IDX_W-1:0])
                   - bsa_pkg::WORD_W'(1);
    end
  end
  assign scan_word = rd_data | ~valid_mask;

  assign zone_limit = (zone_count_r > 4'(NZ)) ? 4'(NZ) : zone_count_r;

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_FIND2) && zf.hit);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : rd_addr;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0
                   : (rd_data | (bsa_pkg::WORD_W'(1) << zf.pos));

  assign offset_full = OFF_W'(bsa_pkg::HDR_BYTES) + OFF_W'(slots_r >> 3)
                     + OFF_W'(slot_r) * OFF_W'(SLOT_BYTES);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    calc_cnt_nxt   = calc_cnt_r;
    slots_nxt      = slots_r;
    zone_nxt       = zone_r;
    base_nxt       = base_r;
    word_nxt       = word_r;
    slot_nxt       = slot_r;
    cnt_inc        = 1'b0;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found_r;
    out_zone_nxt   = out_zone_r;
    out_slot_nxt   = out_slot_r;
    out_offset_nxt = out_offset_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // a request with in_request low is taken and dropped
        if (start && in_request) begin
          calc_cnt_nxt = '0;
          state_nxt    = ST_CALC;
        end
      end
      ST_CALC: begin
        // wait out the divide pipeline so a page size written at accept counts
        calc_cnt_nxt = calc_cnt_r + 2'd1;
        if (calc_cnt_r == 2'd2) begin
          slots_nxt = slots_calc;
          zone_nxt  = '0;
          base_nxt  = '0;
          state_nxt = ST_ZONE;
        end
      end
      ST_ZONE: begin
        if (zone_r >= zone_limit) begin
          // no zone had room
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_zone_nxt   = '0;
          out_slot_nxt   = '0;
          out_offset_nxt = '0;
          state_nxt      = ST_IDLE;
        end else if (!tiny_mask_r[zone_r[2:0]] || (used_cnt_r[zi] >= slots_r)) begin
          zone_nxt = zone_r + 4'd1;
          base_nxt = base_r + AW'(WPZ);
        end else begin
          word_nxt  = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_FIND1;
      end
      ST_FIND1: begin
        state_nxt = ST_FIND2;
      end
      ST_FIND2: begin
        if (zf.hit) begin
          cnt_inc   = 1'b1;
          slot_nxt  = {word_r, zf.pos};
          state_nxt = ST_OFFS;
        end else if (next_base < CMP_W'(slots_r)) begin
          word_nxt  = word_r + WW'(1);
          state_nxt = ST_READ;
        end else begin
          zone_nxt  = zone_r + 4'd1;
          base_nxt  = base_r + AW'(WPZ);
          state_nxt = ST_ZONE;
        end
      end
      ST_OFFS: begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b1;
        out_zone_nxt   = bsa_pkg::ZONE_IDX_W'(zone_r);
        out_slot_nxt   = bsa_pkg::SLOT_IDX_W'(slot_r);
        out_offset_nxt = offset_full[bsa_pkg::OFFSET_W-1:0];
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      calc_cnt_r  <= '0;
      zone_r      <= '0;
      base_r      <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NZ; i++) begin
        used_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      calc_cnt_r  <= calc_cnt_nxt;
      zone_r      <= zone_nxt;
      base_r      <= base_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_inc) begin
        used_cnt_r[zi] <= used_cnt_r[zi] + SLOT_W'(1);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    slots_r      <= slots_nxt;
    slot_r       <= slot_nxt;
    out_found_r  <= out_found_nxt;
    out_zone_r   <= out_zone_nxt;
    out_slot_r   <= out_slot_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_zone_index  = out_zone_r;
  assign out_slot_index  = out_slot_r;
  assign out_byte_offset = out_offset_r;

endmodule
